### design/stepper_step_dir_generator_macros.svh
// Assertion macros for the stepper step/direction generator.
// Each check is sampled on the rising edge of clk_i.
// SSDG_ASSERT is ignored while rst_ni is low; SSDG_ASSERT_ALWAYS also checks during reset.
`ifndef STEPPER_STEP_DIR_GENERATOR_MACROS_SVH
`define STEPPER_STEP_DIR_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define SSDG_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ssdg assertion failed");
`define SSDG_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("ssdg assertion failed during or after reset");
`else
`define SSDG_ASSERT(name, prop)
`define SSDG_ASSERT_ALWAYS(name, prop)
`endif

`endif

### design/ssdg_pkg.sv
// ----------------------------------------------------------------------------
// ssdg_pkg
// Shared types and constants of the step/direction generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssdg_pkg;

  localparam int MODE_W     = 3;
  localparam int STEPS_W    = 32;
  localparam int POS_W      = 32;
  localparam int SPD_W      = 16;
  localparam int LOAD_W     = 19;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [LOAD_W-1:0] LOAD_MAX    = {LOAD_W{1'b1}};
  localparam logic [SPD_W-1:0]  SPEED_RESET = 16'd1000;

  localparam int TIMER_CLOCK_HZ_DEF = 4000000;
  localparam int MIN_SPS_DEF        = 10;
  localparam int MAX_SPS_DEF        = 8000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_MOVE    = 3'd1,
    MODE_STOP    = 3'd2,
    MODE_ZERO    = 3'd3,
    MODE_ENABLE  = 3'd4,
    MODE_DISABLE = 3'd5
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_e;

  typedef struct packed {
    logic apply;      // apply a tick or a simple command
    logic div_start;  // latch a move and start the period division
    logic div_step;   // advance the divider by one bit
    logic commit;     // load the move into the axis state
  } ctrl_cmd_t;

  typedef struct packed {
    logic move_req;   // offered word is a nonzero move
    logic div_last;   // divider is on its final bit
  } dp_stat_t;

endpackage

`default_nettype wire

### design/ssdg_if.sv
// ----------------------------------------------------------------------------
// ssdg_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssdg_cmd_if
  import ssdg_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic        [MODE_W-1:0]  mode;
  logic signed [STEPS_W-1:0] steps;

  modport source (output valid, output mode, output steps, input ready);
  modport sink   (input valid, input mode, input steps, output ready);
endinterface

interface ssdg_res_if
  import ssdg_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    step_pin;
  logic                    dir_pin;
  logic                    enable_pin;
  logic                    busy_res;
  logic signed [POS_W-1:0] position;
  logic                    step_done;

  modport source (output valid, output step_pin, output dir_pin, output enable_pin,
                  output busy_res, output position, output step_done, input ready);
  modport sink   (input valid, input step_pin, input dir_pin, input enable_pin,
                  input busy_res, input position, input step_done, output ready);
endinterface

`default_nettype wire

### design/ssdg_ctrl.sv
// ----------------------------------------------------------------------------
// ssdg_ctrl
// Handshake and sequencing controller: idle / period division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssdg_ctrl
  import ssdg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && stat_i.move_req) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = !out_valid_q || out_ready_i;
        cmd_o.apply     = accept && !stat_i.move_req;
        cmd_o.div_start = accept && stat_i.move_req;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.commit   = stat_i.div_last;
      end
      default: ;
    endcase
  end

  assign accept = in_valid_i && (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.apply || cmd_o.commit) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### design/ssdg_dp.sv
// ----------------------------------------------------------------------------
// ssdg_dp
// Axis datapath: settings, step timing, position and the period divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssdg_dp
  import ssdg_pkg::*;
#(
  parameter int TimerClockHz = TIMER_CLOCK_HZ_DEF,
  parameter int MinSps       = MIN_SPS_DEF,
  parameter int MaxSps       = MAX_SPS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic [MODE_W-1:0]         mode_i,
  input  wire logic signed [STEPS_W-1:0] steps_i,
  input  wire ctrl_cmd_t                 cmd_i,
  output dp_stat_t                       stat_o,
  output logic                           step_pin_o,
  output logic                           dir_pin_o,
  output logic                           enable_pin_o,
  output logic                           busy_o,
  output logic signed [POS_W-1:0]        position_o,
  output logic                           step_done_o
);

  localparam int DivW  = $clog2(TimerClockHz + 1);
  localparam int IterW = $clog2(DivW);

  localparam logic [DivW-1:0]  DIVIDEND = DivW'(TimerClockHz);
  localparam logic [SPD_W-1:0] SPS_MIN  = SPD_W'(MinSps);
  localparam logic [SPD_W-1:0] SPS_MAX  = SPD_W'(MaxSps);

  // settings
  logic [SPD_W-1:0] speed_q;
  logic             inv_q;

  // axis state
  logic [STEPS_W-1:0] rem_q, rem_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               dirneg_q, dirneg_d;
  logic               dirpin_q, dirpin_d;
  logic               busy_q, busy_d;
  logic               en_q, en_d;
  logic               run_q, run_d;
  logic [LOAD_W-1:0]  cnt_q, cnt_d;
  logic [LOAD_W-1:0]  load_q, load_d;
  logic               done_q, done_d;

  // divider and pending move
  logic [DivW-1:0]    dvd_q;
  logic [SPD_W-1:0]   part_q;
  logic [SPD_W-1:0]   dsr_q;
  logic [IterW-1:0]   itr_q;
  logic [STEPS_W-1:0] mag_q;
  logic               neg_q;

  logic [SPD_W:0]     shifted;
  logic               fits;
  logic [SPD_W-1:0]   part_next;
  logic [DivW-1:0]    quo_next;
  logic [DivW-1:0]    quo_m1;
  logic [LOAD_W-1:0]  new_load;
  logic [SPD_W-1:0]   sps_clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SPEED_RESET;
      inv_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPEED:  speed_q <= cfg_data_i[SPD_W-1:0];
        CFG_INVERT: inv_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sps_clamped = speed_q;
    if (speed_q < SPS_MIN) sps_clamped = SPS_MIN;
    if (speed_q > SPS_MAX) sps_clamped = SPS_MAX;
  end

  // restoring division, one quotient bit a cycle
  assign shifted   = {part_q, dvd_q[DivW-1]};
  assign fits      = shifted >= {1'b0, dsr_q};
  assign part_next = fits ? SPD_W'(shifted - {1'b0, dsr_q}) : shifted[SPD_W-1:0];
  assign quo_next  = {dvd_q[DivW-2:0], fits};
  assign quo_m1    = quo_next - DivW'(1);

  always_comb begin
    if (quo_next == '0) begin
      new_load = '0;
    end else if (quo_m1 > DivW'(LOAD_MAX)) begin
      new_load = LOAD_MAX;
    end else begin
      new_load = quo_m1[LOAD_W-1:0];
    end
  end

  assign stat_o.move_req = (mode_i == MODE_MOVE) && (steps_i != '0);
  assign stat_o.div_last = (itr_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q  <= DIVIDEND;
      part_q <= '0;
      dsr_q  <= sps_clamped;
      itr_q  <= IterW'(DivW - 1);
      neg_q  <= steps_i[STEPS_W-1];
      mag_q  <= steps_i[STEPS_W-1] ? (~steps_i + 1'b1) : steps_i;
    end else if (cmd_i.div_step) begin
      dvd_q  <= quo_next;
      part_q <= part_next;
      itr_q  <= itr_q - 1'b1;
    end
  end

  always_comb begin
    rem_d    = rem_q;
    pos_d    = pos_q;
    dirneg_d = dirneg_q;
    dirpin_d = dirpin_q;
    busy_d   = busy_q;
    en_d     = en_q;
    run_d    = run_q;
    cnt_d    = cnt_q;
    load_d   = load_q;
    done_d   = done_q;
    if (cmd_i.apply) begin
      done_d = 1'b0;
      case (mode_i)
        MODE_TICK: begin
          if (run_q) begin
            if (cnt_q == '0) begin
              cnt_d = load_q;
              if (rem_q != '0) begin
                pos_d  = dirneg_q ? pos_q - 1'b1 : pos_q + 1'b1;
                rem_d  = rem_q - 1'b1;
                done_d = 1'b1;
              end
              if (rem_q < STEPS_W'(2)) begin
                run_d  = 1'b0;
                rem_d  = '0;
                busy_d = 1'b0;
              end
            end else begin
              cnt_d = cnt_q - 1'b1;
            end
          end
        end
        MODE_STOP: begin
          run_d  = 1'b0;
          rem_d  = '0;
          busy_d = 1'b0;
        end
        MODE_ZERO: pos_d = '0;
        MODE_ENABLE: en_d = 1'b1;
        MODE_DISABLE: begin
          run_d  = 1'b0;
          rem_d  = '0;
          busy_d = 1'b0;
          en_d   = 1'b0;
        end
        default: ;  // zero-step move and unused codes change nothing but clearing step_done
      endcase
    end
    if (cmd_i.commit) begin
      done_d   = 1'b0;
      dirneg_d = neg_q;
      dirpin_d = ~(neg_q ^ inv_q);
      load_d   = new_load;
      cnt_d    = new_load;
      rem_d    = mag_q;
      busy_d   = 1'b1;
      en_d     = 1'b1;
      run_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      pos_q    <= '0;
      dirneg_q <= 1'b0;
      dirpin_q <= 1'b0;
      busy_q   <= 1'b0;
      en_q     <= 1'b0;
      run_q    <= 1'b0;
      cnt_q    <= '0;
      load_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      rem_q    <= rem_d;
      pos_q    <= pos_d;
      dirneg_q <= dirneg_d;
      dirpin_q <= dirpin_d;
      busy_q   <= busy_d;
      en_q     <= en_d;
      run_q    <= run_d;
      cnt_q    <= cnt_d;
      load_q   <= load_d;
      done_q   <= done_d;
    end
  end

  assign step_pin_o   = run_q && (cnt_q < (load_q >> 1));
  assign dir_pin_o    = dirpin_q;
  assign enable_pin_o = en_q;
  assign busy_o       = busy_q;
  assign position_o   = pos_q;
  assign step_done_o  = done_q;

endmodule

`default_nettype wire

### design/stepper_step_dir_generator.sv
// ----------------------------------------------------------------------------
// stepper_step_dir_generator
// One stepper axis: timer ticks and motion commands in, pin levels out.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake            word
//  --------  ----  -------------------  -----------------------------------------
//  in_i      in    valid / ready        mode, steps
//  out_o     out   valid / ready        step_pin, dir_pin, enable_pin, busy_res,
//                                       position, step_done
//  cfg       in    cfg_we_i (no stall)  cfg_idx_i, cfg_data_i
//
//  Ticks and simple commands are applied on accept; a tick word can be accepted
//  every cycle while the result side keeps taking words.
//  A nonzero move is accepted, then its period is found by a restoring divider,
//  one quotient bit per bit of the timer clock value; no word is taken meanwhile.
//  Reset clears all axis state at once; no clearing pass is needed.
//  A stalled result holds its word; the next command waits until it is taken
//  or is taken in the same cycle.
//
`timescale 1ns / 1ps
`default_nettype none

`include "stepper_step_dir_generator_macros.svh"

module stepper_step_dir_generator
  import ssdg_pkg::*;
#(
  parameter int TimerClockHz = TIMER_CLOCK_HZ_DEF,
  parameter int MinSps       = MIN_SPS_DEF,
  parameter int MaxSps       = MAX_SPS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  ssdg_cmd_if.sink                   in_i,
  ssdg_res_if.source                 out_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing: accept, hold the result word, walk the divider
  ssdg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // axis state doubles as the result register: it only advances on accept or when a move's division ends
  ssdg_dp #(
    .TimerClockHz (TimerClockHz),
    .MinSps       (MinSps),
    .MaxSps       (MaxSps)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (in_i.mode),
    .steps_i      (in_i.steps),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .step_pin_o   (out_o.step_pin),
    .dir_pin_o    (out_o.dir_pin),
    .enable_pin_o (out_o.enable_pin),
    .busy_o       (out_o.busy_res),
    .position_o   (out_o.position),
    .step_done_o  (out_o.step_done)
  );

  // no new word while the divider runs
  `SSDG_ASSERT(a_no_accept_in_div, cmd.div_step |-> !in_i.ready)
  // no result shown for a move before its period is known
  `SSDG_ASSERT(a_no_result_in_div, cmd.div_step |-> !out_o.valid)
  // a completed step can only come from an enabled, running axis
  `SSDG_ASSERT(a_step_needs_enable, out_o.step_done |-> out_o.enable_pin)
  // a running move always has the driver enabled
  `SSDG_ASSERT(a_busy_needs_enable, out_o.busy_res |-> out_o.enable_pin)

endmodule

`default_nettype wire
